// ===== design/twc_pkg.sv =====
// Package for the triangle-wave sound channel: transaction types, event codes,
// the length counter lookup and the sequence-to-level mapping.
// No dependencies; every other design file uses it by scoped names.
package twc_pkg;

    localparam int unsigned PeriodW   = 11;
    localparam int unsigned DividerW  = 12;
    localparam int unsigned LinearW   = 7;
    localparam int unsigned LengthW   = 8;
    localparam int unsigned StepW     = 5;
    localparam int unsigned LevelW    = 4;

    localparam logic [7:0] StatusLengthBit = 8'h04;

    typedef enum logic [2:0] {
        KIND_TICK          = 3'd0,
        KIND_LINEAR_CLOCK  = 3'd1,
        KIND_LENGTH_CLOCK  = 3'd2,
        KIND_CONTROL_WRITE = 3'd3,
        KIND_PERIOD_LOW    = 3'd4,
        KIND_PERIOD_HIGH   = 3'd5,
        KIND_STATUS_WRITE  = 3'd6,
        KIND_STATUS_READ   = 3'd7
    } twc_kind_t;

    typedef struct packed {
        twc_kind_t  kind;
        logic [7:0] data;
        logic       write_collides;
    } twc_in_t;

    typedef struct packed {
        logic [LevelW-1:0] sample;
        logic [7:0]        status_byte;
        logic              length_active;
    } twc_out_t;

    // Standard length counter load values, indexed by bits 7:3 of the high write.
    function automatic logic [LengthW-1:0] length_lookup(input logic [4:0] idx);
        logic [LengthW-1:0] val;
        unique case (idx)
            5'd0:  val = 8'd10;
            5'd1:  val = 8'd254;
            5'd2:  val = 8'd20;
            5'd3:  val = 8'd2;
            5'd4:  val = 8'd40;
            5'd5:  val = 8'd4;
            5'd6:  val = 8'd80;
            5'd7:  val = 8'd6;
            5'd8:  val = 8'd160;
            5'd9:  val = 8'd8;
            5'd10: val = 8'd60;
            5'd11: val = 8'd10;
            5'd12: val = 8'd14;
            5'd13: val = 8'd12;
            5'd14: val = 8'd26;
            5'd15: val = 8'd14;
            5'd16: val = 8'd12;
            5'd17: val = 8'd16;
            5'd18: val = 8'd24;
            5'd19: val = 8'd18;
            5'd20: val = 8'd48;
            5'd21: val = 8'd20;
            5'd22: val = 8'd96;
            5'd23: val = 8'd22;
            5'd24: val = 8'd192;
            5'd25: val = 8'd24;
            5'd26: val = 8'd72;
            5'd27: val = 8'd26;
            5'd28: val = 8'd16;
            5'd29: val = 8'd28;
            5'd30: val = 8'd32;
            default: val = 8'd30;
        endcase
        return val;
    endfunction

    // First half of the sequence falls from 15 to 0, second half rises from 0 to 15.
    function automatic logic [LevelW-1:0] step_level(input logic [StepW-1:0] step);
        return step[StepW-1] ? step[LevelW-1:0] : ~step[LevelW-1:0];
    endfunction

endpackage

// ===== design/twc_core.sv =====
// Channel state and per-transaction update logic for the triangle-wave channel.
// Depends on twc_pkg. Produces the result for the transaction being applied.
module twc_core (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step_en,
    input  twc_pkg::twc_in_t item,
    input  logic           cfg_we,
    input  logic           cfg_wdata,
    output twc_pkg::twc_out_t result
);

    logic                          audible_reg;
    logic                          control_reg,   control_next;
    logic [twc_pkg::LinearW-1:0]   reload_val_reg, reload_val_next;
    logic [twc_pkg::PeriodW-1:0]   period_reg,    period_next;
    logic                          len_en_reg,    len_en_next;
    logic [twc_pkg::LengthW-1:0]   length_reg,    length_next;
    logic                          pending_reg,   pending_next;
    logic [twc_pkg::LinearW-1:0]   linear_reg,    linear_next;
    logic [twc_pkg::LevelW-1:0]    level_reg,     level_next;
    logic [twc_pkg::DividerW-1:0]  divider_reg,   divider_next;
    logic [twc_pkg::StepW-1:0]     seq_reg,       seq_next;
    logic                          skip_reg,      skip_next;
    logic [7:0]                    status;
    logic                          seq_run;

    // The sequencer only runs with both counters live and a period that is not ultrasonic.
    assign seq_run = (length_reg != '0) && (linear_reg != '0)
                     && (period_reg[twc_pkg::PeriodW-1:2] != '0);

    always_comb begin
        control_next    = control_reg;
        reload_val_next = reload_val_reg;
        period_next     = period_reg;
        len_en_next     = len_en_reg;
        length_next     = length_reg;
        pending_next    = pending_reg;
        linear_next     = linear_reg;
        level_next      = level_reg;
        divider_next    = divider_reg;
        seq_next        = seq_reg;
        skip_next       = skip_reg;
        status          = '0;
        unique case (item.kind)
            twc_pkg::KIND_TICK: begin
                if (divider_reg <= twc_pkg::DividerW'(1)) begin
                    divider_next = twc_pkg::DividerW'(period_reg) + twc_pkg::DividerW'(1);
                    if (seq_run) begin
                        seq_next = seq_reg + twc_pkg::StepW'(1);
                        if (audible_reg) begin
                            level_next = twc_pkg::step_level(seq_next);
                        end
                    end
                end else begin
                    divider_next = divider_reg - twc_pkg::DividerW'(1);
                end
            end
            twc_pkg::KIND_LINEAR_CLOCK: begin
                if (pending_reg) begin
                    linear_next = reload_val_reg;
                end else if (linear_reg != '0) begin
                    linear_next = linear_reg - twc_pkg::LinearW'(1);
                end
                if (!control_reg) begin
                    pending_next = 1'b0;
                end
            end
            twc_pkg::KIND_LENGTH_CLOCK: begin
                if (length_reg != '0 && !control_reg) begin
                    length_next = length_reg - twc_pkg::LengthW'(1);
                    if (item.write_collides) begin
                        skip_next = 1'b1;
                    end
                end
            end
            twc_pkg::KIND_CONTROL_WRITE: begin
                control_next    = item.data[7];
                reload_val_next = item.data[6:0];
            end
            twc_pkg::KIND_PERIOD_LOW: begin
                period_next = {period_reg[twc_pkg::PeriodW-1:8], item.data};
            end
            twc_pkg::KIND_PERIOD_HIGH: begin
                period_next = {item.data[2:0], period_reg[7:0]};
                if (len_en_reg && !skip_reg) begin
                    length_next = twc_pkg::length_lookup(item.data[7:3]);
                end
                skip_next    = 1'b0;
                pending_next = 1'b1;
            end
            twc_pkg::KIND_STATUS_WRITE: begin
                len_en_next = item.data[2];
                if (!item.data[2]) begin
                    length_next = '0;
                end
            end
            twc_pkg::KIND_STATUS_READ: begin
                status = (length_reg != '0) ? (item.data | twc_pkg::StatusLengthBit)
                                            : item.data;
            end
        endcase
    end

    always_comb begin
        result.sample        = level_next;
        result.status_byte   = status;
        result.length_active = (length_next != '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            audible_reg    <= 1'b1;
            control_reg    <= 1'b0;
            reload_val_reg <= '0;
            period_reg     <= '0;
            len_en_reg     <= 1'b0;
            length_reg     <= '0;
            pending_reg    <= 1'b0;
            linear_reg     <= '0;
            level_reg      <= '0;
            divider_reg    <= '0;
            seq_reg        <= '0;
            skip_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                audible_reg <= cfg_wdata;
            end
            if (step_en) begin
                control_reg    <= control_next;
                reload_val_reg <= reload_val_next;
                period_reg     <= period_next;
                len_en_reg     <= len_en_next;
                length_reg     <= length_next;
                pending_reg    <= pending_next;
                linear_reg     <= linear_next;
                level_reg      <= level_next;
                divider_reg    <= divider_next;
                seq_reg        <= seq_next;
                skip_reg       <= skip_next;
            end
        end
    end

    // A status write with the enable bit clear always leaves the length counter empty.
    a_status_clears_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_en && item.kind == twc_pkg::KIND_STATUS_WRITE && !item.data[2])
        |=> (length_reg == '0))
        else $error("length counter not cleared by status write");

    // The output level only moves on a timer tick.
    a_level_only_on_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        !(step_en && item.kind == twc_pkg::KIND_TICK) |=> $stable(level_reg))
        else $error("output level changed without a timer tick");

    // The length counter never counts while it is disabled.
    a_length_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        !len_en_reg |-> (length_reg == '0))
        else $error("length counter nonzero while disabled");

endmodule

// ===== design/triangle_wave_channel_top.sv =====
// Top level of the triangle-wave sound channel: input register, result register
// and handshake control around the channel core. Depends on twc_pkg and twc_core.
//
//   Channel  Direction  Handshake          Payload
//   s_       in         s_valid / s_ready  s_payload (twc_in_t: kind, data, write_collides)
//   m_       out        m_valid / m_ready  m_payload (twc_out_t: sample, status_byte,
//                                                     length_active)
//   cfg_     in         cfg_we             cfg_wdata (channel audible flag)
//
// Every accepted transaction produces exactly one result transaction: it waits in the
// input register, and the channel state update plus result capture happen as it moves
// into the result register. Throughput is one transaction per cycle while m_ready is
// high; the only limit is the single result register.
// Reset (aresetn low at a clock edge) empties both registers and restores channel state.
// When m_ready is low with a result waiting, one more transaction is still taken into the
// input register; s_ready then drops until the result register drains.
module triangle_wave_channel_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  twc_pkg::twc_in_t  s_payload,
    output logic              m_valid,
    input  logic              m_ready,
    output twc_pkg::twc_out_t m_payload,
    input  logic              cfg_we,
    input  logic              cfg_wdata
);

    twc_pkg::twc_in_t  in_reg;
    logic              in_valid_reg;
    twc_pkg::twc_out_t out_reg;
    logic              out_valid_reg;
    twc_pkg::twc_out_t core_result;
    logic              advance;

    // The buffered transaction moves into the result register whenever that register is
    // empty or is being emptied in this same cycle. The channel state updates exactly then.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    twc_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .item      (in_reg),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_payload;
        end
        if (advance) begin
            out_reg <= core_result;
        end
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

    // An empty input register must always be able to take a transaction.
    a_empty_accepts: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_ready)
        else $error("input register empty but not ready");

    // A transaction that moves to the output is presented on the next cycle.
    a_advance_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid)
        else $error("result lost after advance");

    // A result taken with nothing behind it leaves the output empty.
    a_drain_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !advance) |=> !m_valid)
        else $error("result repeated after it was taken");

endmodule
